// ----- rtl/core/great_circle_distance_top_assert.svh -----
`ifndef GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH

// Assertion macros for the great-circle distance block.
// The enclosing module must provide clk and rst_n.

// The consequent must hold in the same cycle as the antecedent.
`define GCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, fixed-point constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    // Number of CORDIC iterations in each CORDIC pipeline.
    localparam int CORDIC_STEPS = 32;

    // Angle lanes: latitude difference, latitude sum, longitude difference.
    localparam int LANES     = 3;
    localparam int LANE_DLAT = 0;
    localparam int LANE_SLAT = 1;
    localparam int LANE_DLON = 2;

    // Field widths.
    localparam int LAT_W  = 30;
    localparam int LON_W  = 31;
    localparam int DIST_W = 33;

    // Internal widths.
    localparam int RAW_W    = 33;   // raw coordinate difference or sum
    localparam int ANG_W    = 31;   // angle reduced to one turn
    localparam int FOLD_W   = 30;   // angle folded to half a turn
    localparam int ZQ_W     = 31;   // half angle in radians, Q30
    localparam int UNIT_W   = 31;   // value in [0, 1], Q30
    localparam int ROT_W    = 32;   // rotation CORDIC datapath
    localparam int HAV_W    = 61;   // value in [0, 1], Q60
    localparam int SQ_IN_W  = 62;   // square root radicand, even width
    localparam int SQ_STEPS = SQ_IN_W / 2;
    localparam int ROOT_W   = SQ_IN_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int VEC_W    = 34;   // vectoring CORDIC datapath
    localparam int PROD_W   = 63;   // angle times diameter

    // Fixed-point constants.
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] HALF_DEG_RAD_Q38 = (PI_Q60 / 64'd360) >> 22;
    localparam logic signed [RAW_W-1:0] TURN_Q22     = 33'sd1509949440;
    localparam logic signed [RAW_W-1:0] TWO_TURN_Q22 = 33'sd3019898880;
    localparam logic [ANG_W-1:0]  HALF_TURN_Q22 = 31'd754974720;
    localparam logic signed [ROT_W-1:0] KINV_Q30 = 32'sd652032874;
    localparam logic [UNIT_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [HAV_W-1:0]  ONE_Q60 = 61'h1000_0000_0000_0000;
    localparam logic [31:0]       DIAM_Q8 = 32'd3261952000;
    localparam logic [63:0]       RADIUS_Q8 = 64'd1630976000;
    localparam logic [63:0]       HALF_CIRC_Q8 = ((PI_Q60 >> 30) * RADIUS_Q8) >> 30;
    localparam logic [63:0]       ROUND_HALF_Q30 = 64'h2000_0000;

    // atan(2^-i) in Q30 for the first iterations.
    localparam logic [31:0] ATAN_HEAD [11] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575
    };

    // CORDIC angle for iteration step, Q30.
    function automatic logic [31:0] atan_q30(input int step);
        logic [31:0] r;
        if (step < 11)
        begin
            r = ATAN_HEAD[step];
        end
        else if (step < 30)
        begin
            r = (32'd1 << (30 - step)) - 32'd1;
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gcd_if.sv -----
// ----------------------------------------------------------------------------
// gcd_if
// Valid/ready channels for point pairs and for distances.
// ----------------------------------------------------------------------------
`default_nettype none

// Channel carrying one pair of points per item.
interface gcd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [gcd_pkg::LAT_W-1:0]   first_lat;
    logic signed [gcd_pkg::LON_W-1:0]   first_lon;
    logic signed [gcd_pkg::LAT_W-1:0]   second_lat;
    logic signed [gcd_pkg::LON_W-1:0]   second_lon;

    modport source (output valid, first_lat, first_lon, second_lat, second_lon,
                    input ready);
    modport sink   (input valid, first_lat, first_lon, second_lat, second_lon,
                    output ready);
endinterface

// Channel carrying one distance per item.
interface gcd_out_if;
    logic                         valid;
    logic                         ready;
    logic [gcd_pkg::DIST_W-1:0]   distance_m;

    modport source (output valid, distance_m, input ready);
    modport sink   (input valid, distance_m, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gcd_front.sv -----
// ----------------------------------------------------------------------------
// gcd_front
// Forms the three angle terms, reduces them to one turn, folds them to half a
// turn and scales them to half-angle radians in Q30. Four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic signed [gcd_pkg::LAT_W-1:0]  first_lat,
    input  logic signed [gcd_pkg::LON_W-1:0]  first_lon,
    input  logic signed [gcd_pkg::LAT_W-1:0]  second_lat,
    input  logic signed [gcd_pkg::LON_W-1:0]  second_lon,
    output logic                              out_valid,
    output logic [gcd_pkg::ZQ_W-1:0]          ang [gcd_pkg::LANES]
);
    import gcd_pkg::*;

    localparam int DEPTH = 4;

    logic [DEPTH-1:0]          v_reg;
    logic signed [RAW_W-1:0]   raw_reg  [LANES];
    logic signed [RAW_W-1:0]   raw_next [LANES];
    logic [ANG_W-1:0]          mod_reg  [LANES];
    logic [ANG_W-1:0]          mod_next [LANES];
    logic [FOLD_W-1:0]         fold_reg [LANES];
    logic [FOLD_W-1:0]         fold_next[LANES];
    logic [ZQ_W-1:0]           ang_reg  [LANES];
    logic [ZQ_W-1:0]           ang_next [LANES];

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
    end

    // Differences and the latitude sum.
    always_comb
    begin
        raw_next[LANE_DLAT] = RAW_W'(second_lat) - RAW_W'(first_lat);
        raw_next[LANE_SLAT] = RAW_W'(first_lat) + RAW_W'(second_lat);
        raw_next[LANE_DLON] = RAW_W'(second_lon) - RAW_W'(first_lon);
    end

    // Reduction into [0, one turn) and fold into [0, half a turn].
    always_comb
    begin
        logic signed [RAW_W-1:0] plus1;
        logic signed [RAW_W-1:0] plus2;
        logic signed [RAW_W-1:0] minus1;
        logic [ANG_W-1:0]        back;
        for (int l = 0; l < LANES; l++)
        begin
            plus1  = raw_reg[l] + TURN_Q22;
            plus2  = raw_reg[l] + TWO_TURN_Q22;
            minus1 = raw_reg[l] - TURN_Q22;
            if (raw_reg[l] < 0)
            begin
                mod_next[l] = (plus1 < 0) ? plus2[ANG_W-1:0] : plus1[ANG_W-1:0];
            end
            else if (raw_reg[l] >= TURN_Q22)
            begin
                mod_next[l] = minus1[ANG_W-1:0];
            end
            else
            begin
                mod_next[l] = raw_reg[l][ANG_W-1:0];
            end

            back = TURN_Q22[ANG_W-1:0] - mod_reg[l];
            if (mod_reg[l] > HALF_TURN_Q22)
            begin
                fold_next[l] = back[FOLD_W-1:0];
            end
            else
            begin
                fold_next[l] = mod_reg[l][FOLD_W-1:0];
            end
        end
    end

    // Degrees to half-angle radians.
    always_comb
    begin
        logic [2*FOLD_W+1:0] prod;
        for (int l = 0; l < LANES; l++)
        begin
            prod = (2*FOLD_W+2)'(fold_reg[l]) * (2*FOLD_W+2)'(HALF_DEG_RAD_Q38);
            ang_next[l] = prod[30 +: ZQ_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raw_reg  <= raw_next;
            mod_reg  <= mod_next;
            fold_reg <= fold_next;
            ang_reg  <= ang_next;
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign ang       = ang_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gcd_rot_cordic.sv -----
// ----------------------------------------------------------------------------
// gcd_rot_cordic
// Rotation-mode CORDIC, one iteration per stage, three lanes side by side,
// followed by a stage that clamps each sine to [0, 1].
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_rot_cordic (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [gcd_pkg::ZQ_W-1:0]     ang [gcd_pkg::LANES],
    output logic                         out_valid,
    output logic [gcd_pkg::UNIT_W-1:0]   sine [gcd_pkg::LANES]
);
    import gcd_pkg::*;

    logic [CORDIC_STEPS-1:0]   v_reg;
    logic signed [ROT_W-1:0]   x_reg [CORDIC_STEPS][LANES];
    logic signed [ROT_W-1:0]   y_reg [CORDIC_STEPS][LANES];
    logic signed [ROT_W-1:0]   z_reg [CORDIC_STEPS][LANES];
    logic                      clamp_valid_reg;
    logic [UNIT_W-1:0]         sine_reg  [LANES];
    logic [UNIT_W-1:0]         sine_next [LANES];

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg           <= '0;
            clamp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg           <= {v_reg[CORDIC_STEPS-2:0], in_valid};
            clamp_valid_reg <= v_reg[CORDIC_STEPS-1];
        end
    end

    // One CORDIC iteration per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ROT_W-1:0] ATAN_I = signed'(atan_q30(i));

        logic signed [ROT_W-1:0] xs [LANES];
        logic signed [ROT_W-1:0] ys [LANES];
        logic signed [ROT_W-1:0] zs [LANES];

        if (i == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    xs[l] = KINV_Q30;
                    ys[l] = '0;
                    zs[l] = signed'({1'b0, ang[l]});
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    xs[l] = x_reg[i-1][l];
                    ys[l] = y_reg[i-1][l];
                    zs[l] = z_reg[i-1][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    if (zs[l] >= 0)
                    begin
                        x_reg[i][l] <= xs[l] - (ys[l] >>> i);
                        y_reg[i][l] <= ys[l] + (xs[l] >>> i);
                        z_reg[i][l] <= zs[l] - ATAN_I;
                    end
                    else
                    begin
                        x_reg[i][l] <= xs[l] + (ys[l] >>> i);
                        y_reg[i][l] <= ys[l] - (xs[l] >>> i);
                        z_reg[i][l] <= zs[l] + ATAN_I;
                    end
                end
            end
        end
    end

    // Clamp each sine to [0, 1].
    always_comb
    begin
        logic signed [ROT_W-1:0] yl;
        for (int l = 0; l < LANES; l++)
        begin
            yl = y_reg[CORDIC_STEPS-1][l];
            if (yl < 0)
            begin
                sine_next[l] = '0;
            end
            else if (yl > signed'(ROT_W'(ONE_Q30)))
            begin
                sine_next[l] = ONE_Q30;
            end
            else
            begin
                sine_next[l] = yl[UNIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sine_reg <= sine_next;
        end
    end

    assign out_valid = clamp_valid_reg;
    assign sine      = sine_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gcd_hav.sv -----
// ----------------------------------------------------------------------------
// gcd_hav
// Combines the three sines into the haversine h, clamps h to [0, 1] and hands
// out h and 1 - h. Six stages, each with up to two multipliers or one wide add.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_hav (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [gcd_pkg::UNIT_W-1:0]   sine [gcd_pkg::LANES],
    output logic                         out_valid,
    output logic [gcd_pkg::HAV_W-1:0]    hav_sn,
    output logic [gcd_pkg::HAV_W-1:0]    hav_cs
);
    import gcd_pkg::*;

    localparam int DEPTH = 6;
    localparam int SQ_W  = 2 * UNIT_W;
    localparam int Q_W   = HAV_W + 2;
    localparam int P_W   = 32;
    localparam int M_W   = 64;

    logic [DEPTH-1:0]          v_reg;
    logic [HAV_W-1:0]          a1_reg, a2_reg, a3_reg, a4_reg;
    logic [HAV_W-1:0]          b1_reg;
    logic [UNIT_W-1:0]         c1_reg, c2_reg, c3_reg;
    logic signed [P_W-1:0]     qh2_reg, p3_reg;
    logic signed [Q_W-1:0]     t4_reg;
    logic [HAV_W-1:0]          h5_reg, sn6_reg, cs6_reg;

    logic [SQ_W-1:0]           sq_a, sq_b;
    logic signed [Q_W-1:0]     q_full;
    logic signed [M_W-1:0]     p_full;
    logic signed [Q_W-1:0]     t_next;
    logic signed [Q_W-1:0]     h_sum;
    logic [HAV_W-1:0]          h_next;

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
    end

    // Squares of the latitude sines.
    assign sq_a = SQ_W'(sine[LANE_DLAT]) * SQ_W'(sine[LANE_DLAT]);
    assign sq_b = SQ_W'(sine[LANE_SLAT]) * SQ_W'(sine[LANE_SLAT]);

    // cos(lat1)cos(lat2) as 1 - hav(dlat) - hav(sum), then down to Q30.
    assign q_full = signed'(Q_W'(ONE_Q60)) - signed'(Q_W'(a1_reg))
                    - signed'(Q_W'(b1_reg));

    // Two products with hav's half-angle sine of the longitude difference.
    assign p_full = M_W'(qh2_reg) * M_W'(signed'({1'b0, c2_reg}));
    assign t_next = Q_W'(p3_reg) * Q_W'(signed'({1'b0, c3_reg}));

    // h = hav(dlat) + t, clamped to [0, 1].
    assign h_sum = signed'(Q_W'(a4_reg)) + t4_reg;

    always_comb
    begin
        if (h_sum < 0)
        begin
            h_next = '0;
        end
        else if (h_sum > signed'(Q_W'(ONE_Q60)))
        begin
            h_next = ONE_Q60;
        end
        else
        begin
            h_next = h_sum[HAV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg  <= sq_a[HAV_W-1:0];
            b1_reg  <= sq_b[HAV_W-1:0];
            c1_reg  <= sine[LANE_DLON];

            a2_reg  <= a1_reg;
            qh2_reg <= q_full[30 +: P_W];
            c2_reg  <= c1_reg;

            a3_reg  <= a2_reg;
            p3_reg  <= p_full[30 +: P_W];
            c3_reg  <= c2_reg;

            a4_reg  <= a3_reg;
            t4_reg  <= t_next;

            h5_reg  <= h_next;

            sn6_reg <= h5_reg;
            cs6_reg <= ONE_Q60 - h5_reg;
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign hav_sn    = sn6_reg;
    assign hav_cs    = cs6_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gcd_isqrt.sv -----
// ----------------------------------------------------------------------------
// gcd_isqrt
// Integer floor square roots of two values, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [gcd_pkg::HAV_W-1:0]    rad_sn,
    input  logic [gcd_pkg::HAV_W-1:0]    rad_cs,
    output logic                         out_valid,
    output logic [gcd_pkg::ROOT_W-1:0]   root_sn,
    output logic [gcd_pkg::ROOT_W-1:0]   root_cs
);
    import gcd_pkg::*;

    localparam int SQ_LANES = 2;

    logic [SQ_STEPS-1:0]  v_reg;
    logic [REM_W-1:0]     rem_reg  [SQ_STEPS][SQ_LANES];
    logic [ROOT_W-1:0]    root_reg [SQ_STEPS][SQ_LANES];
    logic [SQ_IN_W-1:0]   rad_reg  [SQ_STEPS][SQ_LANES];

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[SQ_STEPS-2:0], in_valid};
        end
    end

    // Restoring square root: bring down two radicand bits, try root*4+1.
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        logic [REM_W-1:0]   rs [SQ_LANES];
        logic [ROOT_W-1:0]  qs [SQ_LANES];
        logic [SQ_IN_W-1:0] ns [SQ_LANES];

        if (k == 0)
        begin : g_first
            always_comb
            begin
                rs[0] = '0;
                qs[0] = '0;
                ns[0] = SQ_IN_W'(rad_sn);
                rs[1] = '0;
                qs[1] = '0;
                ns[1] = SQ_IN_W'(rad_cs);
            end
        end
        else
        begin : g_next
            always_comb
            begin
                for (int l = 0; l < SQ_LANES; l++)
                begin
                    rs[l] = rem_reg[k-1][l];
                    qs[l] = root_reg[k-1][l];
                    ns[l] = rad_reg[k-1][l];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            logic [REM_W-1:0] shifted;
            logic [REM_W-1:0] trial;
            if (adv)
            begin
                for (int l = 0; l < SQ_LANES; l++)
                begin
                    shifted = {rs[l][REM_W-3:0], ns[l][SQ_IN_W-1 -: 2]};
                    trial   = REM_W'({qs[l], 2'b01});
                    if (shifted >= trial)
                    begin
                        rem_reg[k][l]  <= shifted - trial;
                        root_reg[k][l] <= {qs[l][ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k][l]  <= shifted;
                        root_reg[k][l] <= {qs[l][ROOT_W-2:0], 1'b0};
                    end
                    rad_reg[k][l] <= {ns[l][SQ_IN_W-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = v_reg[SQ_STEPS-1];
    assign root_sn   = root_reg[SQ_STEPS-1][0];
    assign root_cs   = root_reg[SQ_STEPS-1][1];

endmodule

`default_nettype wire

// ----- rtl/core/gcd_vec_cordic.sv -----
// ----------------------------------------------------------------------------
// gcd_vec_cordic
// Vectoring-mode CORDIC giving atan2(sn, cs), one iteration per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_vec_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [gcd_pkg::ROOT_W-1:0]        sn,
    input  logic [gcd_pkg::ROOT_W-1:0]        cs,
    output logic                              out_valid,
    output logic signed [gcd_pkg::VEC_W-1:0]  angle
);
    import gcd_pkg::*;

    logic [CORDIC_STEPS-1:0]   v_reg;
    logic signed [VEC_W-1:0]   x_reg [CORDIC_STEPS];
    logic signed [VEC_W-1:0]   y_reg [CORDIC_STEPS];
    logic signed [VEC_W-1:0]   z_reg [CORDIC_STEPS];

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[CORDIC_STEPS-2:0], in_valid};
        end
    end

    // One CORDIC iteration per stage, driving y toward zero.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [VEC_W-1:0] ATAN_I = VEC_W'(atan_q30(i));

        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic signed [VEC_W-1:0] zs;

        if (i == 0)
        begin : g_first
            assign xs = signed'(VEC_W'(cs));
            assign ys = signed'(VEC_W'(sn));
            assign zs = '0;
        end
        else
        begin : g_next
            assign xs = x_reg[i-1];
            assign ys = y_reg[i-1];
            assign zs = z_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (ys >= 0)
                begin
                    x_reg[i] <= xs + (ys >>> i);
                    y_reg[i] <= ys - (xs >>> i);
                    z_reg[i] <= zs + ATAN_I;
                end
                else
                begin
                    x_reg[i] <= xs - (ys >>> i);
                    y_reg[i] <= ys + (xs >>> i);
                    z_reg[i] <= zs - ATAN_I;
                end
            end
        end
    end

    assign out_valid = v_reg[CORDIC_STEPS-1];
    assign angle     = z_reg[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ----- rtl/core/great_circle_distance_top.sv -----
// ----------------------------------------------------------------------------
// great_circle_distance_top
// Haversine great-circle distance between two points on a 6371 km sphere.
// ----------------------------------------------------------------------------
// Usage:
// - points carries one pair of points per item: latitudes and longitudes in
//   signed degrees with 22 fraction bits. Any bit pattern is accepted.
// - result carries one distance per item, in meters with 8 fraction bits,
//   saturated at half the circumference. Items leave in arrival order.
// - Throughput is one item per cycle while the output is not stalled. The
//   stages in order are front end, rotation CORDIC, haversine, square roots,
//   vectoring CORDIC and scaling.
// - The whole pipeline advances together. points.ready is high whenever the
//   output register is empty or is being taken, so a stalled receiver holds
//   the result and freezes every stage; nothing is lost or repeated.
// - Reset clears all valid bits; the block keeps no other state and is
//   ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_distance_top (
    input  logic        clk,
    input  logic        rst_n,
    gcd_in_if.sink      points,
    gcd_out_if.source   result
);
    import gcd_pkg::*;

    logic                      adv;
    logic                      front_valid;
    logic [ZQ_W-1:0]           front_ang [LANES];
    logic                      rot_valid;
    logic [UNIT_W-1:0]         rot_sine [LANES];
    logic                      hav_valid;
    logic [HAV_W-1:0]          hav_sn;
    logic [HAV_W-1:0]          hav_cs;
    logic                      sq_valid;
    logic [ROOT_W-1:0]         root_sn;
    logic [ROOT_W-1:0]         root_cs;
    logic                      vec_valid;
    logic signed [VEC_W-1:0]   vec_angle;

    logic                      scale_valid_reg;
    logic [PROD_W-1:0]         scale_reg;
    logic [PROD_W-1:0]         scale_next;
    logic [ZQ_W-1:0]           angle_pos;
    logic                      out_valid_reg;
    logic [DIST_W-1:0]         dist_reg;
    logic [DIST_W-1:0]         dist_next;
    logic [63:0]               rounded;

    // The pipeline moves whenever the output register can take a new item.
    assign adv          = !out_valid_reg || result.ready;
    assign points.ready = adv;

    gcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (points.valid),
        .first_lat  (points.first_lat),
        .first_lon  (points.first_lon),
        .second_lat (points.second_lat),
        .second_lon (points.second_lon),
        .out_valid  (front_valid),
        .ang        (front_ang)
    );

    gcd_rot_cordic u_rot (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (front_valid),
        .ang        (front_ang),
        .out_valid  (rot_valid),
        .sine       (rot_sine)
    );

    gcd_hav u_hav (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (rot_valid),
        .sine       (rot_sine),
        .out_valid  (hav_valid),
        .hav_sn     (hav_sn),
        .hav_cs     (hav_cs)
    );

    gcd_isqrt u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (hav_valid),
        .rad_sn     (hav_sn),
        .rad_cs     (hav_cs),
        .out_valid  (sq_valid),
        .root_sn    (root_sn),
        .root_cs    (root_cs)
    );

    gcd_vec_cordic u_vec (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (sq_valid),
        .sn         (root_sn),
        .cs         (root_cs),
        .out_valid  (vec_valid),
        .angle      (vec_angle)
    );

    // Negative angles clamp to zero, then scale by the diameter.
    assign angle_pos  = (vec_angle < 0) ? '0 : vec_angle[ZQ_W-1:0];
    assign scale_next = PROD_W'(angle_pos) * PROD_W'(DIAM_Q8);

    // Round to nearest and saturate at half the circumference.
    assign rounded = 64'(scale_reg) + ROUND_HALF_Q30;

    always_comb
    begin
        if (rounded[63:30] > HALF_CIRC_Q8[33:0])
        begin
            dist_next = HALF_CIRC_Q8[DIST_W-1:0];
        end
        else
        begin
            dist_next = rounded[30 +: DIST_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            scale_valid_reg <= vec_valid;
            out_valid_reg   <= scale_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scale_reg <= scale_next;
            dist_reg  <= dist_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.distance_m = dist_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gcd_checker.sv -----
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks for the great-circle distance block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "great_circle_distance_top_assert.svh"

module gcd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [gcd_pkg::DIST_W-1:0]  distance_m
);
    import gcd_pkg::*;

    // The input side stalls exactly when a finished item is held back.
    `GCD_ASSERT_SAME(a_ready_tracks_output, in_valid || !in_valid, in_ready == (!out_valid || out_ready), "input ready does not follow the output register")

    // Distances never exceed half the circumference.
    `GCD_ASSERT_SAME(a_distance_saturated, out_valid, 64'(distance_m) <= HALF_CIRC_Q8, "distance above half the circumference")

    // A held result keeps its value.
    `GCD_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(distance_m), "result changed while stalled")

    // Nothing comes out right after reset.
    `GCD_ASSERT_SAME(a_empty_after_reset, $rose(rst_n), !out_valid, "result valid right after reset")

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (points.valid),
    .in_ready   (points.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .distance_m (result.distance_m)
);

`default_nettype wire
